/* design/prv_pkg.sv */
// Package for the play request validator: status codes, header and path
// constants, configuration and result structs. No dependencies.
`timescale 1ns / 1ps

package prv_pkg;

  localparam int PREFIX_MAX_DEF = 8;
  localparam int PADDR_W        = 5;
  localparam int PDATA_W        = 64;

  localparam logic [15:0] HDR_BYTES   = 16'd16;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [12:0] STRLEN_MAX  = 13'h1FFF;
  localparam logic [23:0] TAIL_DOTDOT = 24'h2F2E2E;
  localparam logic [7:0]  CHAR_SLASH  = 8'h2F;

  // Register indexes on paddr[4:3]
  localparam logic [1:0] REG_VOLUME_MAX   = 2'd0;
  localparam logic [1:0] REG_PATH_MAX_LEN = 2'd1;
  localparam logic [1:0] REG_PREFIX_BYTES = 2'd2;
  localparam logic [1:0] REG_PREFIX_LEN   = 2'd3;

  localparam logic [30:0] VOLUME_MAX_RST   = 31'd100;
  localparam logic [12:0] PATH_MAX_LEN_RST = 13'd256;

  // Verdict codes; the first failing check wins
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_SHORT     = 3'd1;
  localparam logic [2:0] STAT_BAD_LEN   = 3'd2;
  localparam logic [2:0] STAT_NO_TERM   = 3'd3;
  localparam logic [2:0] STAT_NOT_ABS   = 3'd4;
  localparam logic [2:0] STAT_DOTDOT    = 3'd5;
  localparam logic [2:0] STAT_PREFIX    = 3'd6;

  typedef struct packed {
    logic [30:0] volume_max;
    logic [12:0] path_max_len;
    logic [63:0] prefix_bytes;
    logic [3:0]  prefix_len;
  } prv_cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] play_rate;
    logic [31:0] channel_count;
    logic [30:0] volume;
    logic [12:0] path_length;
  } prv_result_t;

endpackage

/* design/play_request_validator.sv */
// Play request validator, top level. An accepted request byte waits in the input register
// and is parsed when it advances; on the last byte the verdict goes into the result register.
// Throughput: one byte per cycle from the single input register into the parser, unless stalled:
// A verdict waiting on res_stall holds the input register only when it too carries a last byte.
// Reset (rst, synchronous): clears parse state and handshake; registers return to defaults.
// Depends on prv_pkg, prv_cfg_regs and prv_parser.
`timescale 1ns / 1ps

module play_request_validator #(
  parameter int PREFIX_MAX = prv_pkg::PREFIX_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [prv_pkg::PADDR_W-1:0]  paddr,
  input  logic [prv_pkg::PDATA_W-1:0]  pwdata,
  output logic [prv_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  // request bytes
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [7:0]                   req_byte,
  input  logic                         last,
  // verdict
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [2:0]                   status,
  output logic [31:0]                  play_rate,
  output logic [31:0]                  channel_count,
  output logic [30:0]                  volume,
  output logic [12:0]                  path_length
);
  import prv_pkg::*;

  prv_cfg_t    cfg;
  prv_result_t result;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_go;
  logic       req_take;
  logic       res_load;

  prv_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance a non-final byte always; a final byte needs a free (or draining) result register
  assign s1_go     = s1_valid && (!s1_last || !res_valid || !res_stall);
  assign req_stall = s1_valid && !s1_go;
  assign req_take  = req_valid && !req_stall;
  assign res_load  = s1_go && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture payload only on accept
  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_byte <= req_byte;
      s1_last <= last;
    end
  end

  prv_parser #(
    .PREFIX_MAX (PREFIX_MAX)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_go),
    .req_byte (s1_byte),
    .last     (s1_last),
    .cfg      (cfg),
    .result   (result)
  );

  // Result register: drop the valid when taken, load a new verdict on the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status        <= result.status;
      play_rate     <= result.play_rate;
      channel_count <= result.channel_count;
      volume        <= result.volume;
      path_length   <= result.path_length;
    end
  end

  // A stall toward the source only comes from an occupied input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid)
    else $error("request stalled with empty input register");

  // A final byte that advances always shows up as a verdict next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> res_valid)
    else $error("final byte advanced without a verdict");

  // A short request reports zeroed header fields
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == STAT_SHORT) |->
      (play_rate == 32'd0 && channel_count == 32'd0 && volume == 31'd0))
    else $error("short request with nonzero header fields");

  // Path length is reported only on an accepted path, and then it is nonzero
  a_len_only_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((status == STAT_OK) == (path_length != 13'd0)))
    else $error("path length does not match verdict");

endmodule

/* design/prv_cfg_regs.sv */
// Configuration registers behind an APB-style port.
// Depends on prv_pkg for register indexes, reset values and prv_cfg_t.
`timescale 1ns / 1ps

module prv_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [prv_pkg::PADDR_W-1:0]  paddr,
  input  logic [prv_pkg::PDATA_W-1:0]  pwdata,
  output logic [prv_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output prv_pkg::prv_cfg_t            cfg
);
  import prv_pkg::*;

  logic [1:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[4:3];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volume_max   <= VOLUME_MAX_RST;
      cfg.path_max_len <= PATH_MAX_LEN_RST;
      cfg.prefix_bytes <= 64'd0;
      cfg.prefix_len   <= 4'd0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_VOLUME_MAX:   cfg.volume_max   <= pwdata[30:0];
        REG_PATH_MAX_LEN: cfg.path_max_len <= pwdata[12:0];
        REG_PREFIX_BYTES: cfg.prefix_bytes <= pwdata;
        REG_PREFIX_LEN:   cfg.prefix_len   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_VOLUME_MAX:   prdata = {33'd0, cfg.volume_max};
      REG_PATH_MAX_LEN: prdata = {51'd0, cfg.path_max_len};
      REG_PREFIX_BYTES: prdata = cfg.prefix_bytes;
      REG_PREFIX_LEN:   prdata = {60'd0, cfg.prefix_len};
      default:          prdata = '0;
    endcase
  end

endmodule

/* design/prv_parser.sv */
// Per-byte request parser: header words, path checks and the verdict.
// Depends on prv_pkg for constants, prv_cfg_t and prv_result_t.
`timescale 1ns / 1ps

module prv_parser #(
  parameter int PREFIX_MAX = prv_pkg::PREFIX_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            req_byte,
  input  logic                  last,
  input  prv_pkg::prv_cfg_t     cfg,
  output prv_pkg::prv_result_t  result
);
  import prv_pkg::*;

  logic [15:0] byte_count,     byte_count_next;
  logic [31:0] header_words      [4];
  logic [31:0] header_words_next [4];
  logic [23:0] recent_chars,   recent_chars_next;
  logic [12:0] string_length,  string_length_next;
  logic        string_ended,   string_ended_next;
  logic        first_is_slash, first_is_slash_next;
  logic        dotdot_seen,    dotdot_seen_next;
  logic        prefix_ok,      prefix_ok_next;
  logic        terminator_ok,  terminator_ok_next;
  logic        ends_in_dotdot, ends_in_dotdot_next;

  logic [3:0]  prefix_n;
  logic [3:0]  prefix_eff;
  logic [12:0] prefix_eff13;
  logic [7:0]  prefix_char;
  logic [15:0] path_idx;
  logic [31:0] len_word;
  logic        in_path;
  logic [31:0] byte_shifted;
  logic [23:0] recent_shift;
  logic [32:0] need_bytes;
  logic [31:0] vol_word;

  // Effective prefix length: clip to PREFIX_MAX, stop at the first zero char
  always_comb begin
    prefix_n   = (cfg.prefix_len > 4'(PREFIX_MAX)) ? 4'(PREFIX_MAX) : cfg.prefix_len;
    prefix_eff = prefix_n;
    for (int i = PREFIX_MAX - 1; i >= 0; i--) begin
      if ((4'(i) < prefix_n) && (cfg.prefix_bytes[8*i +: 8] == 8'd0)) begin
        prefix_eff = 4'(i);
      end
    end
  end

  assign prefix_eff13 = {9'd0, prefix_eff};
  assign prefix_char  = cfg.prefix_bytes[{string_length[2:0], 3'b000} +: 8];
  assign path_idx     = byte_count - HDR_BYTES;
  assign len_word     = header_words[3];
  assign byte_shifted = 32'(req_byte) << {byte_count[1:0], 3'b000};
  assign recent_shift = {recent_chars[15:0], req_byte};
  assign in_path      = (len_word != 32'd0) && (len_word <= {19'd0, cfg.path_max_len}) &&
                        ({16'd0, path_idx} < len_word);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      header_words_next[k] = header_words[k];
    end
    recent_chars_next   = recent_chars;
    string_length_next  = string_length;
    string_ended_next   = string_ended;
    first_is_slash_next = first_is_slash;
    dotdot_seen_next    = dotdot_seen;
    prefix_ok_next      = prefix_ok;
    terminator_ok_next  = terminator_ok;
    ends_in_dotdot_next = ends_in_dotdot;

    if (byte_count < HDR_BYTES) begin
      for (int k = 0; k < 4; k++) begin
        if (byte_count[3:2] == 2'(k)) begin
          header_words_next[k] = header_words[k] | byte_shifted;
        end
      end
    end else if (in_path) begin
      if ({16'd0, path_idx} == (len_word - 32'd1)) begin
        terminator_ok_next = (req_byte == 8'd0);
      end
      if (!string_ended) begin
        if (req_byte == 8'd0) begin
          string_ended_next = 1'b1;
          if (string_length < prefix_eff13) prefix_ok_next = 1'b0;
        end else begin
          if (path_idx == 16'd0) first_is_slash_next = (req_byte == CHAR_SLASH);
          if ((recent_chars == TAIL_DOTDOT) && (req_byte == CHAR_SLASH)) begin
            dotdot_seen_next = 1'b1;
          end
          if ((string_length < prefix_eff13) && (prefix_char != req_byte)) begin
            prefix_ok_next = 1'b0;
          end
          recent_chars_next   = recent_shift;
          ends_in_dotdot_next = (recent_shift == TAIL_DOTDOT);
          if (string_length != STRLEN_MAX) string_length_next = string_length + 13'd1;
        end
      end
    end

    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 16'd1;
  end

  // Verdict, taken from the state as it stands after this byte
  always_comb begin
    need_bytes = {1'b0, header_words_next[3]} + 33'(HDR_BYTES);
    vol_word   = header_words_next[2];

    if (byte_count_next < HDR_BYTES) begin
      result.status = STAT_SHORT;
    end else if ((header_words_next[3] == 32'd0) ||
                 (header_words_next[3] > {19'd0, cfg.path_max_len}) ||
                 (need_bytes > {17'd0, byte_count_next})) begin
      result.status = STAT_BAD_LEN;
    end else if (!terminator_ok_next) begin
      result.status = STAT_NO_TERM;
    end else if (!first_is_slash_next) begin
      result.status = STAT_NOT_ABS;
    end else if (dotdot_seen_next || ends_in_dotdot_next) begin
      result.status = STAT_DOTDOT;
    end else if (!prefix_ok_next) begin
      result.status = STAT_PREFIX;
    end else begin
      result.status = STAT_OK;
    end

    if (result.status == STAT_SHORT) begin
      result.play_rate     = 32'd0;
      result.channel_count = 32'd0;
      result.volume        = 31'd0;
    end else begin
      result.play_rate     = header_words_next[0];
      result.channel_count = header_words_next[1];
      if (vol_word[31]) begin
        result.volume = 31'd0;
      end else if (vol_word[30:0] > cfg.volume_max) begin
        result.volume = cfg.volume_max;
      end else begin
        result.volume = vol_word[30:0];
      end
    end

    result.path_length = (result.status == STAT_OK) ? header_words_next[3][12:0] : 13'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      byte_count     <= 16'd0;
      for (int k = 0; k < 4; k++) begin
        header_words[k] <= 32'd0;
      end
      recent_chars   <= 24'd0;
      string_length  <= 13'd0;
      string_ended   <= 1'b0;
      first_is_slash <= 1'b0;
      dotdot_seen    <= 1'b0;
      prefix_ok      <= 1'b1;
      terminator_ok  <= 1'b0;
      ends_in_dotdot <= 1'b0;
    end else if (step) begin
      byte_count     <= byte_count_next;
      for (int k = 0; k < 4; k++) begin
        header_words[k] <= header_words_next[k];
      end
      recent_chars   <= recent_chars_next;
      string_length  <= string_length_next;
      string_ended   <= string_ended_next;
      first_is_slash <= first_is_slash_next;
      dotdot_seen    <= dotdot_seen_next;
      prefix_ok      <= prefix_ok_next;
      terminator_ok  <= terminator_ok_next;
      ends_in_dotdot <= ends_in_dotdot_next;
    end
  end

endmodule
